// File: rtl/core/sha_pkg.sv
package sha_pkg;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;
   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [63:0] COUNT_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   function automatic logic [31:0] iv_word(input logic [2:0] i);
      logic [31:0] r;
      case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         3'd7: r = 32'h5be0cd19;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_const(input logic [5:0] t);
      logic [31:0] r;
      case (t)
         6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
         6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
         6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
         6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
         6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
         6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/sha_front.sv
module sha_front #(
   parameter int Depth = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_kind,
   input  logic [7:0]        req_data_byte,
   output logic              q_valid,
   output sha_pkg::item_type q_item,
   input  logic              q_pop
);
   import sha_pkg::*;

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   item_type          mem_ff [Depth];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]       cnt_ff, cnt_in;
   logic              push, pop;

   assign req_stall = (cnt_ff == (AW+1)'(Depth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= '{kind: req_kind, data_byte: req_data_byte};
      end
   end

endmodule

// File: rtl/core/sha_back.sv
module sha_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  sha_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_digest_word,
   output logic [2:0]        rsp_word_index,
   output logic              rsp_last,
   output logic              rsp_overflow_error
);
   import sha_pkg::*;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff;
   logic [63:0] count_ff, len_ff;
   logic        ovf_ff, pad_ff, lenmode_ff, final_ff;
   logic [31:0] win_ff [16];
   logic [31:0] chain_ff [8];
   logic [31:0] v_ff [8];
   logic [5:0]  rnd_ff;
   logic [2:0]  idx_ff;

   logic        wr_en;
   logic [7:0]  wr_byte;
   logic        start_round;
   logic [7:0]  pad_byte;
   logic [31:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2;

   assign q_pop              = (state_ff == ST_IDLE);
   assign rsp_valid          = (state_ff == ST_EMIT);
   assign rsp_digest_word    = chain_ff[idx_ff];
   assign rsp_word_index     = idx_ff;
   assign rsp_last           = (idx_ff == 3'd7);
   assign rsp_overflow_error = ovf_ff;

   assign pad_byte = (lenmode_ff && fill_ff >= 6'd56) ?
                     len_ff[8*(7 - fill_ff[2:0]) +: 8] : 8'h00;

   // Schedule expansion and one compression round.
   always_comb begin
      s0    = {win_ff[1][6:0], win_ff[1][31:7]} ^ {win_ff[1][17:0], win_ff[1][31:18]}
              ^ (win_ff[1] >> 3);
      s1    = {win_ff[14][16:0], win_ff[14][31:17]} ^ {win_ff[14][18:0], win_ff[14][31:19]}
              ^ (win_ff[14] >> 10);
      w_new = win_ff[0] + s0 + win_ff[9] + s1;
      big1  = {v_ff[4][5:0], v_ff[4][31:6]} ^ {v_ff[4][10:0], v_ff[4][31:11]}
              ^ {v_ff[4][24:0], v_ff[4][31:25]};
      ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1    = v_ff[7] + big1 + ch + round_const(rnd_ff) + win_ff[0];
      big0  = {v_ff[0][1:0], v_ff[0][31:2]} ^ {v_ff[0][12:0], v_ff[0][31:13]}
              ^ {v_ff[0][21:0], v_ff[0][31:22]};
      maj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2    = big0 + maj;
   end

   always_comb begin
      state_in    = state_ff;
      wr_en       = 1'b0;
      wr_byte     = 8'h00;
      start_round = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.kind == KIND_FINISH) begin
                  wr_en   = 1'b1;
                  wr_byte = PAD_MARK;
                  if (fill_ff == 6'd63) begin
                     start_round = 1'b1;
                  end else begin
                     state_in = ST_PAD;
                  end
               end else if (count_ff != COUNT_MAX) begin
                  wr_en       = 1'b1;
                  wr_byte     = q_item.data_byte;
                  start_round = (fill_ff == 6'd63);
               end
            end
         end
         ST_PAD: begin
            wr_en       = 1'b1;
            wr_byte     = pad_byte;
            start_round = (fill_ff == 6'd63);
         end
         ST_ROUND: begin
            if (rnd_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (final_ff) begin
               state_in = ST_EMIT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall && idx_ff == 3'd7) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (start_round) begin
         state_in = ST_ROUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
         pad_ff     <= 1'b0;
         lenmode_ff <= 1'b0;
         final_ff   <= 1'b0;
         rnd_ff     <= '0;
         idx_ff     <= '0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= iv_word(3'(i));
         end
      end else begin
         if (wr_en) begin
            fill_ff <= fill_ff + 6'd1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  if (q_item.kind == KIND_FINISH) begin
                     pad_ff     <= 1'b1;
                     final_ff   <= 1'b0;
                     lenmode_ff <= (fill_ff <= 6'd55) || (fill_ff == 6'd63);
                  end else if (count_ff == COUNT_MAX) begin
                     ovf_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + 64'd1;
                  end
               end
            end
            ST_PAD: begin
               if (fill_ff == 6'd63) begin
                  final_ff   <= lenmode_ff;
                  lenmode_ff <= 1'b1;
               end
            end
            ST_ROUND: begin
               rnd_ff <= rnd_ff + 6'd1;
            end
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) begin
                  chain_ff[i] <= chain_ff[i] + v_ff[i];
               end
            end
            ST_EMIT: begin
               if (!rsp_stall) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) begin
                        chain_ff[i] <= iv_word(3'(i));
                     end
                     count_ff <= '0;
                     ovf_ff   <= 1'b0;
                     pad_ff   <= 1'b0;
                     final_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
         if (start_round) begin
            rnd_ff <= '0;
         end
      end
   end

   // Payload: block window, working variables and captured bit length.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid && q_item.kind == KIND_FINISH) begin
         len_ff <= {count_ff[60:0], 3'b000};
      end
      if (wr_en) begin
         win_ff[fill_ff[5:2]][8*(3 - fill_ff[1:0]) +: 8] <= wr_byte;
      end
      if (start_round) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= chain_ff[i];
         end
      end
      if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[15] <= w_new;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

endmodule

// File: rtl/core/sha256_byte_stream_hasher_unit.sv
// Channel  | Direction | Ports                                   | Moves
// req      | in        | req_valid/req_stall, kind, data_byte    | one byte or finish word
// rsp      | out       | rsp_valid/rsp_stall, digest word fields | one digest word
//
// The back end takes a data word while idle; every 64th byte starts a compression
// (64 rounds of the single round unit plus one fold) before it takes the next.
// A finish word pads one byte per cycle, runs one or two compressions and then
// presents eight digest words, one per accepted cycle.
// Reset is synchronous and active high; it restores the initial hash values.
// The four-word intake queue keeps taking words, until it is full, while the back
// end compresses or waits on a stalled result.
module sha256_byte_stream_hasher_unit #(
   parameter int QueueDepth = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last,
   output logic        rsp_overflow_error
);
   import sha_pkg::*;

   // Words cross from the intake queue to the hashing engine here.
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   sha_front #(.Depth(QueueDepth)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   // The engine holds the block window, the chaining words and the counters.
   sha_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last           (rsp_last),
      .rsp_overflow_error (rsp_overflow_error)
   );

endmodule

// File: rtl/core/sha_checker.sv
module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last,
   input logic        rsp_overflow_error
);

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_word_index == 3'd7)))
      else $error("last flag does not match word index");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_word)
      && $stable(rsp_word_index))
      else $error("stalled digest word changed");

   a_next_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
      rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest words not consecutive");

   a_flag_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last && !rsp_stall |=> $stable(rsp_overflow_error))
      else $error("overflow flag changed within a digest");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sha256_byte_stream_hasher_unit sha_checker u_sha_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_digest_word    (rsp_digest_word),
   .rsp_word_index     (rsp_word_index),
   .rsp_last           (rsp_last),
   .rsp_overflow_error (rsp_overflow_error)
);

// File: dv/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the SHA-256 byte stream hasher.
//
// Message bytes and finish words are queued by an initial block and presented
// by a clocked driver. When a word is accepted, the driver runs its own SHA-256
// model of the unit and, on a finish word, queues the eight digest words it
// expects. A clocked monitor takes every accepted digest word and compares it,
// field by field, with the oldest expected word.
//
// Idling runs in three phases, chosen by how many words have been accepted.
// First the sender idles about 31 percent of the time and the receiver 63 percent.
// Then the two figures swap. At the end neither side idles.
// Some messages are held back until every digest already owed has arrived, so
// the unit is also seen starting from a fully drained state.
// The byte counter cannot reach its limit in a run of this length, so every
// digest word is expected with the overflow flag clear.
module tb_top;
   import sha_pkg::*;

   typedef struct {
      logic       kind;
      logic [7:0] data_byte;
      bit         hold;
   } pending_word_type;

   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
      logic        overflow_error;
   } digest_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last;
   logic        rsp_overflow_error;

   pending_word_type send_queue[$];
   digest_word_type  digest_queue[$];
   int               accepted_count;
   int               error_count;

   // The model's own copy of the hashing state.
   logic [31:0] hash_state[8];
   logic [7:0]  block_bytes[64];
   int          block_fill;
   logic [63:0] byte_total;
   logic        count_overflow;

   localparam logic [31:0] START_HASH[8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K[64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   sha256_byte_stream_hasher_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last           (rsp_last),
      .rsp_overflow_error (rsp_overflow_error)
   );

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      logic [63:0] both;
      both = {x, x} >> n;
      return both[31:0];
   endfunction

   // One 64-round compression of the buffered block into the hash state.
   task automatic compress_block();
      logic [31:0] sched[64];
      logic [31:0] v[8];
      logic [31:0] s0, s1, t1, t2;
      for (int t = 0; t < 16; t++)
         sched[t] = {block_bytes[4*t], block_bytes[4*t+1],
                     block_bytes[4*t+2], block_bytes[4*t+3]};
      for (int t = 16; t < 64; t++) begin
         s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
         s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
         sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + sched[t];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
      block_fill = 0;
      byte_total = '0;
      count_overflow = 1'b0;
   endtask

   // Applies one accepted word to the model; a finish word queues the digest.
   task automatic absorb_word(input logic kind, input logic [7:0] data_byte);
      logic [63:0]     bit_len;
      digest_word_type d;
      if (kind == KIND_DATA) begin
         if (byte_total == COUNT_MAX) begin
            count_overflow = 1'b1;
         end else begin
            byte_total++;
            block_bytes[block_fill] = data_byte;
            block_fill++;
            if (block_fill == 64) begin
               compress_block();
               block_fill = 0;
            end
         end
      end else begin
         bit_len = byte_total << 3;
         block_bytes[block_fill] = PAD_MARK;
         block_fill++;
         if (block_fill > 56) begin
            for (int i = block_fill; i < 64; i++) block_bytes[i] = 8'h00;
            compress_block();
            block_fill = 0;
         end
         for (int i = block_fill; i < 56; i++) block_bytes[i] = 8'h00;
         for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            d.digest_word    = hash_state[i];
            d.word_index     = 3'(i);
            d.last           = (i == 7);
            d.overflow_error = count_overflow;
            digest_queue.push_back(d);
         end
         restart_message();
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic queue_message(input int length, input bit hold);
      pending_word_type w;
      for (int i = 0; i < length; i++) begin
         w.kind = KIND_DATA;
         w.data_byte = 8'($urandom_range(0, 255));
         w.hold = hold && (i == 0);
         send_queue.push_back(w);
      end
      w.kind = KIND_FINISH;
      w.data_byte = 8'($urandom_range(0, 255));
      w.hold = hold && (length == 0);
      send_queue.push_back(w);
   endtask

   task automatic queue_word(input logic kind, input logic [7:0] data_byte);
      pending_word_type w;
      w.kind = kind;
      w.data_byte = data_byte;
      w.hold = 1'b0;
      send_queue.push_back(w);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The idling phase follows the number of words accepted so far.
   function automatic int idle_phase();
      if (accepted_count < 105) return 0;
      if (accepted_count < 210) return 1;
      return 2;
   endfunction

   // Driver: takes note of the word accepted at this edge, then decides what
   // to present next. A held word waits until no digest word is owed.
   always @(posedge clock) begin
      int               pct;
      bit               go;
      pending_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         req_kind <= KIND_DATA;
         req_data_byte <= 8'h00;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_word(req_kind, req_data_byte);
            accepted_count++;
         end
         if (!req_valid || !req_stall) begin
            pct = (idle_phase() == 0) ? 31 : (idle_phase() == 1) ? 63 : 0;
            go = send_queue.size() > 0 && $urandom_range(0, 99) >= pct;
            if (go && send_queue[0].hold && digest_queue.size() != 0) go = 0;
            if (go) begin
               w = send_queue.pop_front();
               req_valid <= 1'b1;
               req_kind <= w.kind;
               req_data_byte <= w.data_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted digest word and sets the next stall.
   always @(posedge clock) begin
      int              pct;
      digest_word_type d;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected digest word %h", rsp_digest_word));
            end else begin
               d = digest_queue.pop_front();
               if (rsp_digest_word !== d.digest_word)
                  report_mismatch($sformatf("digest word %h, expected %h",
                                            rsp_digest_word, d.digest_word));
               if (rsp_word_index !== d.word_index)
                  report_mismatch($sformatf("word index %0d, expected %0d",
                                            rsp_word_index, d.word_index));
               if (rsp_last !== d.last)
                  report_mismatch($sformatf("last %b, expected %b", rsp_last, d.last));
               if (rsp_overflow_error !== d.overflow_error)
                  report_mismatch($sformatf("overflow %b, expected %b",
                                            rsp_overflow_error, d.overflow_error));
            end
         end
         pct = (idle_phase() == 0) ? 63 : (idle_phase() == 1) ? 31 : 0;
         rsp_stall <= ($urandom_range(0, 99) < pct);
      end
   end

   initial begin
      int length;
      accepted_count = 0;
      error_count = 0;
      restart_message();
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_DATA;
      req_data_byte = 8'h00;
      rsp_stall = 1'b0;

      // Directed words: the empty message (its finish word carrying a full
      // byte), "abc", a message of the extreme byte values and another empty one.
      queue_word(KIND_FINISH, 8'hff);
      queue_word(KIND_DATA, 8'h61);
      queue_word(KIND_DATA, 8'h62);
      queue_word(KIND_DATA, 8'h63);
      queue_word(KIND_FINISH, 8'h00);
      queue_word(KIND_DATA, 8'h00);
      queue_word(KIND_DATA, 8'hff);
      queue_word(KIND_DATA, 8'h80);
      queue_word(KIND_DATA, 8'h7f);
      queue_word(KIND_FINISH, 8'h55);
      queue_word(KIND_FINISH, 8'haa);

      // Random messages: mostly short, with regular lengths either side of the
      // points where padding needs a second block or a block is exactly full.
      queue_message(56, 1'b1);
      while (send_queue.size() < 310) begin
         if ($urandom_range(0, 2) == 0)
            length = 54 + $urandom_range(0, 12);
         else
            length = $urandom_range(0, 20);
         queue_message(length, $urandom_range(0, 4) == 0);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (send_queue.size() != 0 || req_valid || digest_queue.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && digest_queue.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
